// File: rtl/core/nste_pkg.sv
// Shared types and constants of the noise swept tone effect engine.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package nste_pkg;

   // Field widths of the request, response and register words
   localparam int unsigned ACTION_W  = 2;
   localparam int unsigned CODE_W    = 3;
   localparam int unsigned RANGE_W   = 16;
   localparam int unsigned CMP_W     = 8;
   localparam int unsigned PRE_W     = 2;
   localparam int unsigned TICK_W    = 32;
   localparam int unsigned NOISE_W   = 16;
   localparam int unsigned REMAIN_W  = 8;
   localparam int unsigned PHASE_W   = 5;
   localparam int unsigned FILL_W    = 6;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 8;
   localparam int unsigned PROD_W    = 32;

   // Actions of a request word
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd2;

   // Effect codes
   localparam logic [CODE_W-1:0] FX_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] FX_FILL    = 3'd1;
   localparam logic [CODE_W-1:0] FX_CRASH   = 3'd2;
   localparam logic [CODE_W-1:0] FX_DEFAULT = 3'd3;
   localparam logic [CODE_W-1:0] FX_PUSH    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_FILL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_CRASH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_DEFAULT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_PUSH    = 2'd3;

   // Register reset values
   localparam logic [FILL_W-1:0]   DUR_FILL_RST    = 6'd15;
   localparam logic [REMAIN_W-1:0] DUR_CRASH_RST   = 8'd10;
   localparam logic [REMAIN_W-1:0] DUR_DEFAULT_RST = 8'd10;
   localparam logic [REMAIN_W-1:0] DUR_PUSH_RST    = 8'd40;

   // Noise generator
   localparam logic [NOISE_W-1:0] NOISE_TAPS  = 16'hB400;
   localparam logic [NOISE_W-1:0] NOISE_SEED  = 16'h0001;
   localparam logic [RANGE_W-1:0] SPAN_FILL    = 16'd55;
   localparam logic [RANGE_W-1:0] SPAN_CRASH   = 16'd440;
   localparam logic [RANGE_W-1:0] SPAN_PUSH    = 16'd30;
   localparam logic [RANGE_W-1:0] SPAN_DEFAULT = 16'd10;

   // Frequency formula terms
   localparam int FREQ_HIGH_BASE = 660;
   localparam int FREQ_PUSH_BASE = 60;

   // Tone divider
   localparam logic [RANGE_W-1:0] DIV_COARSE_LIMIT = 16'd256;
   localparam logic [PRE_W-1:0]   PRESCALE_FINE    = 2'd2;
   localparam logic [PRE_W-1:0]   PRESCALE_COARSE  = 2'd3;

   // Operations of the serial arithmetic unit
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } unit_ctl_type;

endpackage

// File: rtl/core/nste_req_if.sv
// Request channel of the effect engine: action, effect code and draw range.
// Depends on nste_pkg for field widths.
interface nste_req_if;
   logic                                valid;
   logic                                ready;
   logic [nste_pkg::ACTION_W-1:0]       action;
   logic [nste_pkg::CODE_W-1:0]         effect_code;
   logic [nste_pkg::RANGE_W-1:0]        rand_range;

   modport source (output valid, action, effect_code, rand_range, input ready);
   modport sink   (input valid, action, effect_code, rand_range, output ready);
endinterface

// File: rtl/core/nste_rsp_if.sv
// Response channel of the effect engine: tone settings, tick count, draw result.
// Depends on nste_pkg for field widths.
interface nste_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                tone_on;
   logic                                tone_update;
   logic [nste_pkg::CMP_W-1:0]          compare_value;
   logic [nste_pkg::PRE_W-1:0]          prescale_code;
   logic [nste_pkg::TICK_W-1:0]         elapsed_ticks;
   logic [nste_pkg::CODE_W-1:0]         effect_locking;
   logic [nste_pkg::NOISE_W-1:0]        random_value;

   modport source (output valid, tone_on, tone_update, compare_value, prescale_code,
                   elapsed_ticks, effect_locking, random_value, input ready);
   modport sink   (input valid, tone_on, tone_update, compare_value, prescale_code,
                   elapsed_ticks, effect_locking, random_value, output ready);
endinterface

// File: rtl/core/nste_csr_if.sv
// Register write channel of the effect engine: index and data.
// Depends on nste_pkg for field widths.
interface nste_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nste_pkg::CSR_IDX_W-1:0]      index;
   logic [nste_pkg::CSR_DAT_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/nste_serial_unit.sv
// Shared serial arithmetic unit: 16x16 shift-add multiply, restoring divide.
// One 33-bit adder serves both; depends on nste_pkg.
module nste_serial_unit #(
   parameter int unsigned QUO_W = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nste_pkg::unit_ctl_type        ctl,
   input  logic [nste_pkg::RANGE_W-1:0]  opa,
   input  logic [nste_pkg::RANGE_W-1:0]  opb,
   input  logic [QUO_W-1:0]              dividend,
   output logic                          done,
   output logic [nste_pkg::PROD_W-1:0]   product,
   output logic [QUO_W-1:0]              quotient
);

   localparam int unsigned MAX_N = (QUO_W > nste_pkg::RANGE_W) ? QUO_W : nste_pkg::RANGE_W;
   localparam int unsigned CNT_W = $clog2(MAX_N);
   localparam int unsigned W     = nste_pkg::PROD_W;
   localparam int unsigned RW    = nste_pkg::RANGE_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     acc_ff, acc_in;     // product, or remainder in the low half
   logic [W-1:0]     mcand_ff, mcand_in;
   logic [RW-1:0]    mplier_ff, mplier_in; // multiplier, or divisor
   logic [QUO_W-1:0] quo_ff, quo_in;

   logic [W-1:0]     add_x, add_y;
   logic             add_cin;
   logic [W:0]       add_sum;
   logic [RW:0]      part_rem;

   // Shared adder
   assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};

   // Shift the next dividend bit into the partial remainder
   assign part_rem = {acc_ff[RW-1:0], quo_ff[QUO_W-1]};

   always_comb begin
      if (op_ff == nste_pkg::OP_DIV) begin
         add_x   = W'(part_rem);
         add_y   = ~W'(mplier_ff);
         add_cin = 1'b1;
      end else begin
         add_x   = acc_ff;
         add_y   = mplier_ff[0] ? mcand_ff : '0;
         add_cin = 1'b0;
      end
   end

   // Sequence the iterations
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      quo_in    = quo_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         op_in     = ctl.op;
         acc_in    = '0;
         mcand_in  = W'(opa);
         mplier_in = opb;
         quo_in    = dividend;
         cnt_in    = (ctl.op == nste_pkg::OP_DIV) ? CNT_W'(QUO_W - 1) : CNT_W'(RW - 1);
      end else if (busy_ff) begin
         if (op_ff == nste_pkg::OP_DIV) begin
            acc_in = add_sum[W] ? W'(add_sum[RW-1:0]) : W'(part_rem[RW-1:0]);
            quo_in = {quo_ff[QUO_W-2:0], add_sum[W]};
         end else begin
            acc_in    = add_sum[W-1:0];
            mcand_in  = {mcand_ff[W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[RW-1:1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      quo_ff    <= quo_in;
   end

   assign done     = done_ff;
   assign product  = acc_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/noise_swept_tone_effect_engine.sv
// Noise swept tone effect engine: sequencer around nste_serial_unit.
// Start, stop, unknown, non-stepping and effect-ending tick words go straight to the response;
// a random draw runs 16 multiply steps; a tick that steps an effect with steps left runs a draw,
// then QUO_W = clog2(CLOCK_HZ/16+1) divide steps. One word at a time: the next is taken once
// the response is loaded, later while an earlier response still waits. Synchronous reset
// restores the defaults, noise to one.
module noise_swept_tone_effect_engine #(
   parameter int unsigned CLOCK_HZ    = 8000000,
   parameter int unsigned STEP_DIVIDE = 20
) (
   input  logic       clock,
   input  logic       reset,
   nste_req_if.sink   req_port,
   nste_rsp_if.source rsp_port,
   nste_csr_if.sink   csr_port
);

   localparam int unsigned DIVIDEND = CLOCK_HZ / 16;
   localparam int unsigned QUO_W    = $clog2(DIVIDEND + 1);
   localparam logic [nste_pkg::PHASE_W-1:0] STEP_LAST = nste_pkg::PHASE_W'(STEP_DIVIDE);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DRAW   = 3'd1;
   localparam logic [2:0] ST_FREQ   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam int unsigned RW = nste_pkg::RANGE_W;

   // Control and model state
   logic [2:0]                       state_ff, state_in;
   logic [nste_pkg::TICK_W-1:0]      tick_ff, tick_in;
   logic [nste_pkg::PHASE_W-1:0]     phase_ff, phase_in;
   logic [nste_pkg::CODE_W-1:0]      kind_ff, kind_in;
   logic [nste_pkg::REMAIN_W-1:0]    remain_ff, remain_in;
   logic [nste_pkg::NOISE_W-1:0]     lfsr_ff, lfsr_in;
   logic                             tone_en_ff, tone_en_in;
   logic [nste_pkg::CMP_W-1:0]       tone_cmp_ff, tone_cmp_in;
   logic [nste_pkg::PRE_W-1:0]       tone_pre_ff, tone_pre_in;
   logic [nste_pkg::FILL_W-1:0]      dur_fill_ff;
   logic [nste_pkg::REMAIN_W-1:0]    dur_crash_ff, dur_default_ff, dur_push_ff;
   logic                             update_ff, update_in;
   logic                             draw_only_ff, draw_only_in;
   logic [RW-1:0]                    rnd_ff, rnd_in;

   // Response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_tone_on_ff, rsp_update_ff;
   logic [nste_pkg::CMP_W-1:0]       rsp_cmp_ff;
   logic [nste_pkg::PRE_W-1:0]       rsp_pre_ff;
   logic [nste_pkg::TICK_W-1:0]      rsp_ticks_ff;
   logic [nste_pkg::CODE_W-1:0]      rsp_lock_ff;
   logic [RW-1:0]                    rsp_rnd_ff;
   logic                             rsp_load;

   // Serial unit hookup
   nste_pkg::unit_ctl_type           unit_ctl;
   logic [RW-1:0]                    unit_a, unit_b;
   logic                             unit_done;
   logic [nste_pkg::PROD_W-1:0]      unit_prod;
   logic [QUO_W-1:0]                 unit_quo;

   logic                             req_take;
   logic [nste_pkg::NOISE_W-1:0]     lfsr_next;
   logic [RW-1:0]                    step_span;
   logic signed [17:0]               t_s, r_s, freq_s;
   logic [RW-1:0]                    freq;
   logic [nste_pkg::PROD_W-1:0]      quo_wide;
   logic [RW-1:0]                    div_sat, div_scaled, div_minus;

   nste_serial_unit #(
      .QUO_W (QUO_W)
   ) u_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (unit_ctl),
      .opa      (unit_a),
      .opb      (unit_b),
      .dividend (QUO_W'(DIVIDEND)),
      .done     (unit_done),
      .product  (unit_prod),
      .quotient (unit_quo)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   // Advance the Galois noise generator by one shift
   assign lfsr_next = {1'b0, lfsr_ff[nste_pkg::NOISE_W-1:1]}
                      ^ (lfsr_ff[0] ? nste_pkg::NOISE_TAPS : '0);

   // Pick the noise span of the active effect
   always_comb begin
      case (kind_ff)
         nste_pkg::FX_FILL:  step_span = nste_pkg::SPAN_FILL;
         nste_pkg::FX_CRASH: step_span = nste_pkg::SPAN_CRASH;
         nste_pkg::FX_PUSH:  step_span = nste_pkg::SPAN_PUSH;
         default:            step_span = nste_pkg::SPAN_DEFAULT;
      endcase
   end

   // Tone frequency from remaining steps (not for crash) and noise, clamped to at least one
   assign t_s = $signed({10'b0, remain_ff});
   assign r_s = $signed({2'b0, rnd_ff});
   always_comb begin
      case (kind_ff)
         nste_pkg::FX_FILL:
            freq_s = 18'(nste_pkg::FREQ_HIGH_BASE) - (t_s * 18'sd10) + r_s;
         nste_pkg::FX_CRASH:
            freq_s = 18'(nste_pkg::FREQ_HIGH_BASE) + r_s;
         nste_pkg::FX_PUSH:
            freq_s = 18'(nste_pkg::FREQ_PUSH_BASE) + (t_s * 18'sd16) + r_s;
         default:
            freq_s = 18'(nste_pkg::FREQ_HIGH_BASE) + (t_s * 18'sd5) + r_s;
      endcase
   end
   assign freq = (freq_s < 18'sd1) ? RW'(1) : freq_s[RW-1:0];

   // Saturate the quotient, then choose the prescaler
   assign quo_wide   = nste_pkg::PROD_W'(unit_quo);
   assign div_sat    = (|quo_wide[nste_pkg::PROD_W-1:RW]) ? '1 : quo_wide[RW-1:0];
   assign div_scaled = (div_sat > nste_pkg::DIV_COARSE_LIMIT) ? {3'b0, div_sat[RW-1:3]}
                                                              : div_sat;
   assign div_minus  = div_scaled - RW'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      remain_in    = remain_ff;
      lfsr_in      = lfsr_ff;
      tone_en_in   = tone_en_ff;
      tone_cmp_in  = tone_cmp_ff;
      tone_pre_in  = tone_pre_ff;
      update_in    = update_ff;
      draw_only_in = draw_only_ff;
      rnd_in       = rnd_ff;
      rsp_load     = 1'b0;
      unit_ctl     = '{start: 1'b0, op: nste_pkg::OP_MUL};
      unit_a       = lfsr_next;
      unit_b       = step_span;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               update_in    = 1'b0;
               draw_only_in = (req_port.action == nste_pkg::ACT_DRAW);
               state_in     = ST_FINISH;
               case (req_port.action)
                  nste_pkg::ACT_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     phase_in = phase_ff + 1'b1;
                     if (phase_ff >= STEP_LAST) begin
                        phase_in = '0;
                        if (kind_ff != nste_pkg::FX_NONE) begin
                           update_in = 1'b1;
                           if (remain_ff > 8'd1) begin
                              // Count down and draw noise for the new tone
                              remain_in      = remain_ff - 1'b1;
                              lfsr_in        = lfsr_next;
                              unit_ctl.start = 1'b1;
                              state_in       = ST_DRAW;
                           end else begin
                              // Effect over: silence the tone
                              remain_in  = '0;
                              tone_en_in = 1'b0;
                              kind_in    = nste_pkg::FX_NONE;
                           end
                        end
                     end
                  end
                  nste_pkg::ACT_START: begin
                     case (req_port.effect_code)
                        nste_pkg::FX_NONE: remain_in = '0;
                        nste_pkg::FX_FILL: begin
                           remain_in = nste_pkg::REMAIN_W'(dur_fill_ff);
                           kind_in   = req_port.effect_code;
                        end
                        nste_pkg::FX_CRASH: begin
                           remain_in = dur_crash_ff;
                           kind_in   = req_port.effect_code;
                        end
                        nste_pkg::FX_DEFAULT: begin
                           remain_in = dur_default_ff;
                           kind_in   = req_port.effect_code;
                        end
                        nste_pkg::FX_PUSH: begin
                           remain_in = dur_push_ff;
                           kind_in   = req_port.effect_code;
                        end
                        default: ;
                     endcase
                  end
                  nste_pkg::ACT_DRAW: begin
                     lfsr_in        = lfsr_next;
                     unit_b         = req_port.rand_range;
                     unit_ctl.start = 1'b1;
                     state_in       = ST_DRAW;
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAW: begin
            if (unit_done) begin
               rnd_in   = unit_prod[nste_pkg::PROD_W-1:RW];
               state_in = draw_only_ff ? ST_FINISH : ST_FREQ;
            end
         end
         ST_FREQ: begin
            unit_ctl = '{start: 1'b1, op: nste_pkg::OP_DIV};
            unit_b   = freq;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (unit_done) begin
               tone_en_in  = 1'b1;
               tone_pre_in = (div_sat > nste_pkg::DIV_COARSE_LIMIT) ?
                             nste_pkg::PRESCALE_COARSE : nste_pkg::PRESCALE_FINE;
               tone_cmp_in = div_minus[nste_pkg::CMP_W-1:0];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the response word until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         phase_ff     <= '0;
         kind_ff      <= nste_pkg::FX_NONE;
         remain_ff    <= '0;
         lfsr_ff      <= nste_pkg::NOISE_SEED;
         tone_en_ff   <= 1'b0;
         tone_cmp_ff  <= '0;
         tone_pre_ff  <= '0;
         update_ff    <= 1'b0;
         draw_only_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         remain_ff    <= remain_in;
         lfsr_ff      <= lfsr_in;
         tone_en_ff   <= tone_en_in;
         tone_cmp_ff  <= tone_cmp_in;
         tone_pre_ff  <= tone_pre_in;
         update_ff    <= update_in;
         draw_only_ff <= draw_only_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rnd_ff <= rnd_in;
   end

   // Duration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dur_fill_ff    <= nste_pkg::DUR_FILL_RST;
         dur_crash_ff   <= nste_pkg::DUR_CRASH_RST;
         dur_default_ff <= nste_pkg::DUR_DEFAULT_RST;
         dur_push_ff    <= nste_pkg::DUR_PUSH_RST;
      end else if (csr_port.valid && csr_port.ready) begin
         unique case (csr_port.index)
            nste_pkg::CSR_DUR_FILL:    dur_fill_ff    <= csr_port.data[nste_pkg::FILL_W-1:0];
            nste_pkg::CSR_DUR_CRASH:   dur_crash_ff   <= csr_port.data;
            nste_pkg::CSR_DUR_DEFAULT: dur_default_ff <= csr_port.data;
            nste_pkg::CSR_DUR_PUSH:    dur_push_ff    <= csr_port.data;
            default: ;
         endcase
      end
   end

   // Capture the response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tone_on_ff <= tone_en_ff;
         rsp_update_ff  <= update_ff;
         rsp_cmp_ff     <= tone_cmp_ff;
         rsp_pre_ff     <= tone_pre_ff;
         rsp_ticks_ff   <= tick_ff;
         rsp_lock_ff    <= {1'b0, kind_ff[1:0]};
         rsp_rnd_ff     <= draw_only_ff ? rnd_ff : '0;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.tone_on        = rsp_tone_on_ff;
   assign rsp_port.tone_update    = rsp_update_ff;
   assign rsp_port.compare_value  = rsp_cmp_ff;
   assign rsp_port.prescale_code  = rsp_pre_ff;
   assign rsp_port.elapsed_ticks  = rsp_ticks_ff;
   assign rsp_port.effect_locking = rsp_lock_ff;
   assign rsp_port.random_value   = rsp_rnd_ff;

endmodule
